// ----- src/nwh_pkg.sv -----
`timescale 1ns / 1ps

package nwh_pkg;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic [1:0] KIND_ACK   = 2'd0;
	localparam logic [1:0] KIND_POINT = 2'd1;
	localparam logic [1:0] KIND_EMPTY = 2'd2;

	localparam logic REG_POINT_COUNT  = 1'b0;
	localparam logic REG_POINTS_AHEAD = 1'b1;

	localparam int COORD_W = 32;
	localparam int YAW_W   = 16;
	localparam int XW      = 40;   // cordic x/y datapath
	localparam int ZW      = 24;   // cordic angle accumulator, q.16 rad
	localparam int CORDIC_STEPS = 17;

	localparam logic [4:0] LAST_ITER = 5'(CORDIC_STEPS - 1);
	localparam logic [6:0] AHEAD_RESET = 7'd61;

	localparam logic signed [YAW_W-1:0] YAW_PI      = 16'sd25736;
	localparam logic signed [YAW_W-1:0] YAW_HALF_PI = 16'sd12868;
	localparam logic signed [ZW-1:0]    Z_PI        = 24'sd205887;
	localparam logic signed [XW-1:0]    NORM_HI     = 40'sd4294967296;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ACK,
		ST_EMPTY,
		ST_SCAN,
		ST_RD_CUR,
		ST_CAP_CUR,
		ST_RD_NXT,
		ST_HEAD_INIT,
		ST_NORM,
		ST_ROT,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		RD_SCAN,
		RD_CUR,
		RD_NXT
	} rd_sel_t;

	typedef struct packed {
		logic       wr_point;
		logic       pose_load;
		logic       scan_clear;
		logic       hz_init;
		logic       rd_en;
		rd_sel_t    rd_sel;
		logic       cap_cur;
		logic       head_init;
		logic       norm_step;
		logic       rot_step;
		logic       out_load;
		logic [1:0] out_kind;
		logic       out_last;
		logic       advance;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic scan_done;
		logic special;
		logic norm_done;
		logic rot_done;
		logic last_step;
	} sts_t;

	// atan(2^-i) in q.16 rad
	function automatic logic signed [ZW-1:0] atan_lut(input logic [4:0] i);
		logic signed [ZW-1:0] r;
		case (i)
			5'd0:    r = 24'sd51472;
			5'd1:    r = 24'sd30386;
			5'd2:    r = 24'sd16055;
			5'd3:    r = 24'sd8150;
			5'd4:    r = 24'sd4091;
			5'd5:    r = 24'sd2047;
			5'd6:    r = 24'sd1024;
			5'd7:    r = 24'sd512;
			5'd8:    r = 24'sd256;
			5'd9:    r = 24'sd128;
			5'd10:   r = 24'sd64;
			5'd11:   r = 24'sd32;
			5'd12:   r = 24'sd16;
			5'd13:   r = 24'sd8;
			5'd14:   r = 24'sd4;
			5'd15:   r = 24'sd2;
			5'd16:   r = 24'sd1;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// ----- src/nearest_waypoint_horizon_generator.sv -----
`timescale 1ns / 1ps

// nearest waypoint horizon generator
// input channel (in_valid/in_stall) takes load or query items; output channel
// (out_valid/out_stall) returns results; cfg_valid/cfg_ready writes point_count
// (index 0) and points_ahead (index 1), always ready; the user must write
// them only while idle, the block does not enforce it. a load writes one store
// slot and returns one ack. a query scans the first n stored points through a
// 4 stage distance pipeline (one store read per cycle), then walks k points of
// the path. the first point takes two store reads and each later point one;
// unless the heading vector lies on an axis, a point then needs operand
// normalization (one doubling per cycle) and 17 cordic iterations.
// an empty table returns one empty item for the query.
// one item is in work at a time; in_stall is high until its last result sits
// in the output register. a stalled receiver holds the output register and the
// block waits before writing the next result.
// reset clears control state and the configuration (point_count 0,
// points_ahead 61); the waypoint store is not cleared and must be loaded.
module nearest_waypoint_horizon_generator #(
	parameter int MAX_POINTS = 1024,
	parameter int MAX_AHEAD  = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               opcode,
	input  logic [9:0]         point_index,
	input  logic signed [31:0] coord_x,
	input  logic signed [31:0] coord_y,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         kind,
	output logic [9:0]         nearest_index,
	output logic [5:0]         step,
	output logic signed [31:0] ref_x,
	output logic signed [31:0] ref_y,
	output logic signed [15:0] ref_yaw,
	output logic               last,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_index,
	input  logic [10:0]        cfg_data
);

	nwh_pkg::cmd_t cmd;
	nwh_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	nwh_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.opcode    (opcode),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	nwh_dp #(
		.MAX_POINTS (MAX_POINTS),
		.MAX_AHEAD  (MAX_AHEAD)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_valid && cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.point_index   (point_index),
		.coord_x       (coord_x),
		.coord_y       (coord_y),
		.cmd           (cmd),
		.sts           (sts),
		.kind          (kind),
		.nearest_index (nearest_index),
		.step          (step),
		.ref_x         (ref_x),
		.ref_y         (ref_y),
		.ref_yaw       (ref_yaw),
		.last          (last)
	);

endmodule

// ----- src/nwh_ctrl.sv -----
`timescale 1ns / 1ps

module nwh_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  logic           opcode,
	output logic           out_valid,
	input  logic           out_stall,
	input  nwh_pkg::sts_t  sts,
	output nwh_pkg::cmd_t  cmd
);

	nwh_pkg::state_t state_q, state_d;
	logic out_valid_q;
	logic accept;
	logic out_free;

	assign in_stall  = (state_q != nwh_pkg::ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nwh_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			nwh_pkg::ST_IDLE: begin
				if (accept) begin
					if (opcode == nwh_pkg::OP_LOAD) begin
						state_d = nwh_pkg::ST_ACK;
					end else if (sts.empty) begin
						state_d = nwh_pkg::ST_EMPTY;
					end else begin
						state_d = nwh_pkg::ST_SCAN;
					end
				end
			end
			nwh_pkg::ST_ACK, nwh_pkg::ST_EMPTY: begin
				if (out_free) state_d = nwh_pkg::ST_IDLE;
			end
			nwh_pkg::ST_SCAN: begin
				if (sts.scan_done) state_d = nwh_pkg::ST_RD_CUR;
			end
			nwh_pkg::ST_RD_CUR:  state_d = nwh_pkg::ST_CAP_CUR;
			nwh_pkg::ST_CAP_CUR: state_d = nwh_pkg::ST_HEAD_INIT;
			nwh_pkg::ST_RD_NXT:  state_d = nwh_pkg::ST_HEAD_INIT;
			nwh_pkg::ST_HEAD_INIT: begin
				state_d = sts.special ? nwh_pkg::ST_EMIT : nwh_pkg::ST_NORM;
			end
			nwh_pkg::ST_NORM: begin
				if (sts.norm_done) state_d = nwh_pkg::ST_ROT;
			end
			nwh_pkg::ST_ROT: begin
				if (sts.rot_done) state_d = nwh_pkg::ST_EMIT;
			end
			nwh_pkg::ST_EMIT: begin
				if (out_free) begin
					state_d = sts.last_step ? nwh_pkg::ST_IDLE : nwh_pkg::ST_RD_NXT;
				end
			end
			default: state_d = nwh_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.rd_sel = nwh_pkg::RD_SCAN;
		case (state_q)
			nwh_pkg::ST_IDLE: begin
				if (accept) begin
					if (opcode == nwh_pkg::OP_LOAD) begin
						cmd.wr_point = 1'b1;
					end else begin
						cmd.pose_load  = 1'b1;
						cmd.scan_clear = 1'b1;
					end
				end
			end
			nwh_pkg::ST_ACK: begin
				cmd.out_load = out_free;
				cmd.out_kind = nwh_pkg::KIND_ACK;
				cmd.out_last = 1'b1;
			end
			nwh_pkg::ST_EMPTY: begin
				cmd.out_load = out_free;
				cmd.out_kind = nwh_pkg::KIND_EMPTY;
				cmd.out_last = 1'b1;
			end
			nwh_pkg::ST_SCAN: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_sel  = nwh_pkg::RD_SCAN;
				cmd.hz_init = sts.scan_done;
			end
			nwh_pkg::ST_RD_CUR: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = nwh_pkg::RD_CUR;
			end
			nwh_pkg::ST_CAP_CUR: begin
				cmd.cap_cur = 1'b1;
				cmd.rd_en   = 1'b1;
				cmd.rd_sel  = nwh_pkg::RD_NXT;
			end
			nwh_pkg::ST_RD_NXT: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = nwh_pkg::RD_NXT;
			end
			nwh_pkg::ST_HEAD_INIT: begin
				cmd.head_init = 1'b1;
			end
			nwh_pkg::ST_NORM: begin
				cmd.norm_step = !sts.norm_done;
			end
			nwh_pkg::ST_ROT: begin
				cmd.rot_step = 1'b1;
			end
			nwh_pkg::ST_EMIT: begin
				cmd.out_load = out_free;
				cmd.out_kind = nwh_pkg::KIND_POINT;
				cmd.out_last = sts.last_step;
				cmd.advance  = out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// never overwrite a result the receiver has not taken
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || !out_stall))
		else $error("output register overwritten");

	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_load && cmd.out_last) |=> (state_q == nwh_pkg::ST_IDLE))
		else $error("final transaction did not return to idle");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == nwh_pkg::ST_ROT && sts.rot_done) |=> (state_q == nwh_pkg::ST_EMIT))
		else $error("cordic finished without emit");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == nwh_pkg::ST_SCAN && !sts.scan_done) |=> (state_q == nwh_pkg::ST_SCAN))
		else $error("left scan early");

endmodule

// ----- src/nwh_dp.sv -----
`timescale 1ns / 1ps

module nwh_dp #(
	parameter int MAX_POINTS = 1024,
	parameter int MAX_AHEAD  = 64,
	parameter int AW = $clog2(MAX_POINTS),
	parameter int CW = $clog2(MAX_POINTS + 1),
	parameter int KW = $clog2(MAX_AHEAD + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [10:0]        cfg_data,
	input  logic [9:0]         point_index,
	input  logic signed [31:0] coord_x,
	input  logic signed [31:0] coord_y,
	input  nwh_pkg::cmd_t      cmd,
	output nwh_pkg::sts_t      sts,
	output logic [1:0]         kind,
	output logic [9:0]         nearest_index,
	output logic [5:0]         step,
	output logic signed [31:0] ref_x,
	output logic signed [31:0] ref_y,
	output logic signed [15:0] ref_yaw,
	output logic               last
);

	localparam int XW = nwh_pkg::XW;
	localparam int ZW = nwh_pkg::ZW;

	// configuration
	logic [10:0] point_count_q;
	logic [6:0]  points_ahead_q;
	logic [CW-1:0] n_eff;
	logic [KW-1:0] k_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q  <= '0;
			points_ahead_q <= nwh_pkg::AHEAD_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				nwh_pkg::REG_POINT_COUNT:  point_count_q  <= cfg_data;
				nwh_pkg::REG_POINTS_AHEAD: points_ahead_q <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (32'(point_count_q) > 32'(MAX_POINTS)) n_eff = CW'(MAX_POINTS);
		else n_eff = CW'(point_count_q);
		if (points_ahead_q == 7'd0) k_eff = KW'(1);
		else if (32'(points_ahead_q) > 32'(MAX_AHEAD)) k_eff = KW'(MAX_AHEAD);
		else k_eff = KW'(points_ahead_q);
	end

	// waypoint store
	logic [63:0] mem [MAX_POINTS];
	logic [63:0] rd_data_q;
	logic        wr_en;
	logic        rd_en;
	logic [AW-1:0] rd_addr;
	logic signed [31:0] rd_x, rd_y;

	assign wr_en = cmd.wr_point && (32'(point_index) < 32'(MAX_POINTS));
	assign rd_x = rd_data_q[63:32];
	assign rd_y = rd_data_q[31:0];

	always_ff @(posedge clk) begin
		if (wr_en) mem[AW'(point_index)] <= {coord_x, coord_y};
		if (rd_en) rd_data_q <= mem[rd_addr];
	end

	// pose
	logic signed [31:0] px_q, py_q;
	always_ff @(posedge clk) begin
		if (cmd.pose_load) begin
			px_q <= coord_x;
			py_q <= coord_y;
		end
	end

	// nearest search pipeline
	logic [CW-1:0] issue_q;
	logic          scan_issue;
	logic          v_s1, v_s2, v_s3;
	logic [AW-1:0] idx_s1, idx_s2, idx_s3;
	logic [31:0]   ax_s2, ay_s2;
	logic [63:0]   sx_s3, sy_s3;
	logic [64:0]   sq_sum;
	logic [64:0]   best_d_q;
	logic [AW-1:0] best_q;
	logic          first_q;
	logic signed [32:0] sdx, sdy;

	assign scan_issue = cmd.rd_en && (cmd.rd_sel == nwh_pkg::RD_SCAN) && (issue_q < n_eff);
	assign sdx  = 33'(rd_x) - 33'(px_q);
	assign sdy  = 33'(rd_y) - 33'(py_q);
	assign sq_sum = {1'b0, sx_s3} + {1'b0, sy_s3};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			first_q <= 1'b1;
		end else if (cmd.scan_clear) begin
			issue_q <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			first_q <= 1'b1;
		end else begin
			if (scan_issue) issue_q <= issue_q + CW'(1);
			v_s1 <= scan_issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (v_s3) first_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= issue_q[AW-1:0];
		idx_s2 <= idx_s1;
		ax_s2  <= sdx[32] ? 32'(-sdx) : sdx[31:0];
		ay_s2  <= sdy[32] ? 32'(-sdy) : sdy[31:0];
		idx_s3 <= idx_s2;
		sx_s3  <= ax_s2 * ax_s2;
		sy_s3  <= ay_s2 * ay_s2;
		// strict compare keeps the earliest index on a tie
		if (v_s3 && (first_q || sq_sum < best_d_q)) begin
			best_d_q <= sq_sum;
			best_q   <= idx_s3;
		end
	end

	// horizon walk
	logic [AW-1:0] cur_idx_q;
	logic [AW-1:0] nxt_idx;
	logic [CW-1:0] inc;
	logic [KW-1:0] step_q;
	logic signed [31:0] cur_x_q, cur_y_q, nx_q, ny_q;

	assign inc     = CW'(cur_idx_q) + CW'(1);
	assign nxt_idx = (inc >= n_eff) ? '0 : AW'(inc);

	always_comb begin
		rd_en   = cmd.rd_en && ((cmd.rd_sel != nwh_pkg::RD_SCAN) || scan_issue);
		case (cmd.rd_sel)
			nwh_pkg::RD_SCAN: rd_addr = issue_q[AW-1:0];
			nwh_pkg::RD_CUR:  rd_addr = cur_idx_q;
			nwh_pkg::RD_NXT:  rd_addr = nxt_idx;
			default:          rd_addr = cur_idx_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.hz_init) begin
			cur_idx_q <= best_q;
			step_q    <= '0;
		end else if (cmd.advance) begin
			cur_idx_q <= nxt_idx;
			step_q    <= step_q + KW'(1);
			cur_x_q   <= nx_q;
			cur_y_q   <= ny_q;
		end
		if (cmd.cap_cur) begin
			cur_x_q <= rd_x;
			cur_y_q <= rd_y;
		end
		if (cmd.head_init) begin
			nx_q <= rd_x;
			ny_q <= rd_y;
		end
	end

	// heading: cordic vectoring
	logic signed [32:0]    hdx, hdy;
	logic signed [XW-1:0]  hdx_e, hdy_e;
	logic                  hspecial;
	logic signed [15:0]    hspec_yaw;
	logic signed [XW-1:0]  cx_q, cy_q, xs, ys;
	logic signed [ZW-1:0]  z_q, zr, zsat;
	logic [4:0]            it_q;
	logic                  special_q;
	logic signed [15:0]    spec_yaw_q;
	logic signed [15:0]    yaw;

	assign hdx   = 33'(rd_x) - 33'(cur_x_q);
	assign hdy   = 33'(rd_y) - 33'(cur_y_q);
	assign hdx_e = XW'(hdx);
	assign hdy_e = XW'(hdy);

	always_comb begin
		hspecial  = (hdy == '0) || (hdx == '0);
		hspec_yaw = '0;
		if (hdy == '0) begin
			hspec_yaw = hdx[32] ? nwh_pkg::YAW_PI : 16'sd0;
		end else if (hdx == '0) begin
			hspec_yaw = hdy[32] ? -nwh_pkg::YAW_HALF_PI : nwh_pkg::YAW_HALF_PI;
		end
	end

	assign xs = cx_q >>> it_q;
	assign ys = cy_q >>> it_q;

	always_ff @(posedge clk) begin
		if (cmd.head_init) begin
			special_q  <= hspecial;
			spec_yaw_q <= hspec_yaw;
			it_q       <= '0;
			// left half plane: rotate by pi first
			if (hdx[32]) begin
				cx_q <= -hdx_e;
				cy_q <= -hdy_e;
				z_q  <= hdy[32] ? -nwh_pkg::Z_PI : nwh_pkg::Z_PI;
			end else begin
				cx_q <= hdx_e;
				cy_q <= hdy_e;
				z_q  <= '0;
			end
		end else if (cmd.norm_step) begin
			cx_q <= cx_q <<< 1;
			cy_q <= cy_q <<< 1;
		end else if (cmd.rot_step) begin
			it_q <= it_q + 5'd1;
			if (cy_q > 0) begin
				cx_q <= cx_q + ys;
				cy_q <= cy_q - xs;
				z_q  <= z_q + nwh_pkg::atan_lut(it_q);
			end else begin
				cx_q <= cx_q - ys;
				cy_q <= cy_q + xs;
				z_q  <= z_q - nwh_pkg::atan_lut(it_q);
			end
		end
	end

	always_comb begin
		zr = (z_q + ZW'(4)) >>> 3;
		if (zr > ZW'(nwh_pkg::YAW_PI)) zsat = ZW'(nwh_pkg::YAW_PI);
		else if (zr < -ZW'(nwh_pkg::YAW_PI)) zsat = -ZW'(nwh_pkg::YAW_PI);
		else zsat = zr;
		yaw = special_q ? spec_yaw_q : 16'(zsat);
	end

	// status
	always_comb begin
		sts.empty     = (n_eff == '0);
		sts.scan_done = (issue_q == n_eff) && !v_s1 && !v_s2 && !v_s3;
		sts.special   = hspecial;
		sts.norm_done = (cx_q >= nwh_pkg::NORM_HI) || (cx_q <= -nwh_pkg::NORM_HI) ||
		                (cy_q >= nwh_pkg::NORM_HI) || (cy_q <= -nwh_pkg::NORM_HI);
		sts.rot_done  = (it_q == nwh_pkg::LAST_ITER);
		sts.last_step = (step_q == k_eff - KW'(1));
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			kind <= cmd.out_kind;
			last <= cmd.out_last;
			if (cmd.out_kind == nwh_pkg::KIND_POINT) begin
				nearest_index <= 10'(best_q);
				step          <= 6'(step_q);
				ref_x         <= cur_x_q;
				ref_y         <= cur_y_q;
				ref_yaw       <= yaw;
			end else begin
				nearest_index <= '0;
				step          <= '0;
				ref_x         <= '0;
				ref_y         <= '0;
				ref_yaw       <= '0;
			end
		end
	end

endmodule
